FILE: rtl/bitmap_inode_sector_allocator_core_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_INODE_SECTOR_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_INODE_SECTOR_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BISA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BISA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BISA_ASSERT(lbl, clk, rst, prop, msg)
`define BISA_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

FILE: rtl/bisa_pkg.sv
// Shared types, codes and constants of the bitmap inode and sector allocator.
package bisa_pkg;

   localparam int SECTOR_BYTES_DEF     = 512;
   localparam int IMAP_MAX_SECTORS_DEF = 1;
   localparam int SMAP_MAX_SECTORS_DEF = 8;

   localparam int OP_W       = 2;
   localparam int COUNT_W    = 8;
   localparam int INDEX_W    = 12;
   localparam int VALUE_W    = 8;
   localparam int NUMBER_W   = 17;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int IMAP_REG_W  = 1;
   localparam int SMAP_REG_W  = 4;
   localparam int FDS_W       = 16;
   localparam int SEC_W       = 7;

   localparam logic [7:0] FULL_BYTE = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_INODE     = 2'd0,
      OP_ALLOC_SECTORS   = 2'd1,
      OP_LOAD_INODE_MAP  = 2'd2,
      OP_LOAD_SECTOR_MAP = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_OVERLAP = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INODE_MAP_SECTORS  = 2'd0,
      CSR_SECTOR_MAP_SECTORS = 2'd1,
      CSR_FIRST_DATA_SECTOR  = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_RUN_RD,
      S_RUN_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic scan_step;
      logic set_full;
      logic mark;
      logic run_read;
      logic run_write;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic   clear_last;
      op_type req_op;
      logic   req_count_zero;
      op_type cur_op;
      logic   scan_hit;
      logic   scan_empty;
      logic   run_fits;
      logic   run_last;
      logic   rsp_free;
   } dp_status_type;

endpackage

FILE: rtl/bisa_ctrl.sv
// Sequencer of the allocator: clear pass, map scan, run marking and result hand-off.
module bisa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  bisa_pkg::dp_status_type stat,
   output bisa_pkg::cmd_type       cmd
);

   bisa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bisa_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bisa_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = bisa_pkg::S_IDLE;
            end
         end
         bisa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               unique case (stat.req_op)
                  bisa_pkg::OP_ALLOC_INODE: state_in = bisa_pkg::S_SCAN;
                  bisa_pkg::OP_ALLOC_SECTORS: begin
                     state_in = stat.req_count_zero ? bisa_pkg::S_DONE : bisa_pkg::S_SCAN;
                  end
                  default: state_in = bisa_pkg::S_DONE;
               endcase
            end
         end
         bisa_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit) begin
               if (stat.cur_op == bisa_pkg::OP_ALLOC_INODE) begin
                  state_in = bisa_pkg::S_MARK;
               end else if (stat.run_fits) begin
                  state_in = bisa_pkg::S_RUN_RD;
               end else begin
                  cmd.set_full = 1'b1;
                  state_in     = bisa_pkg::S_DONE;
               end
            end else if (stat.scan_empty) begin
               cmd.set_full = 1'b1;
               state_in     = bisa_pkg::S_DONE;
            end
         end
         bisa_pkg::S_MARK: begin
            cmd.mark = 1'b1;
            state_in = bisa_pkg::S_DONE;
         end
         bisa_pkg::S_RUN_RD: begin
            cmd.run_read = 1'b1;
            state_in     = bisa_pkg::S_RUN_WR;
         end
         bisa_pkg::S_RUN_WR: begin
            cmd.run_write = 1'b1;
            state_in      = stat.run_last ? bisa_pkg::S_DONE : bisa_pkg::S_RUN_RD;
         end
         bisa_pkg::S_DONE: begin
            // hold the result until the output register is free
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = bisa_pkg::S_IDLE;
            end
         end
         default: state_in = bisa_pkg::S_CLEAR;
      endcase
   end

endmodule

FILE: rtl/bisa_dp.sv
// Datapath of the allocator: both map memories, scan and run logic, result register.
module bisa_dp #(
   parameter int SECTOR_BYTES     = bisa_pkg::SECTOR_BYTES_DEF,
   parameter int IMAP_MAX_SECTORS = bisa_pkg::IMAP_MAX_SECTORS_DEF,
   parameter int SMAP_MAX_SECTORS = bisa_pkg::SMAP_MAX_SECTORS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bisa_pkg::cmd_type                    cmd,
   output bisa_pkg::dp_status_type              stat,
   input  logic [bisa_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [bisa_pkg::IMAP_REG_W-1:0]      inode_map_sectors,
   input  logic [bisa_pkg::SMAP_REG_W-1:0]      sector_map_sectors,
   input  logic [bisa_pkg::FDS_W-1:0]           first_data_sector,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bisa_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int IMAP_BYTES = SECTOR_BYTES * IMAP_MAX_SECTORS;
   localparam int SMAP_BYTES = SECTOR_BYTES * SMAP_MAX_SECTORS;
   localparam int MAP_BYTES  = (IMAP_BYTES > SMAP_BYTES) ? IMAP_BYTES : SMAP_BYTES;
   localparam int IMAP_AW    = $clog2(IMAP_BYTES);
   localparam int SMAP_AW    = $clog2(SMAP_BYTES);
   localparam int ADDR_W     = $clog2(MAP_BYTES);
   localparam int CNT_W      = $clog2(MAP_BYTES + 1);
   localparam int BIT_W      = CNT_W + 3;
   localparam int CMP_W      = (CNT_W > bisa_pkg::INDEX_W) ? CNT_W : bisa_pkg::INDEX_W;
   localparam int NW         = bisa_pkg::NUMBER_W;

   // lowest clear bit of a byte that is known not to be all ones
   function automatic logic [2:0] first_zero(input logic [7:0] b);
      logic [2:0] pos;
      pos = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!b[k]) begin
            pos = 3'(k);
         end
      end
      return pos;
   endfunction

   // request fields
   bisa_pkg::op_type                 req_op;
   logic [bisa_pkg::COUNT_W-1:0]     req_count;
   logic [bisa_pkg::INDEX_W-1:0]     req_index;
   logic [bisa_pkg::VALUE_W-1:0]     req_value;
   logic [CMP_W-1:0]                 idx_cmp;

   assign req_op    = bisa_pkg::op_type'(req_tdata[1:0]);
   assign req_count = req_tdata[9:2];
   assign req_index = req_tdata[21:10];
   assign req_value = req_tdata[29:22];
   assign idx_cmp   = CMP_W'(req_index);

   // in-use limits in bytes
   localparam int SEC_CLAMP_W = bisa_pkg::SEC_W;
   logic [SEC_CLAMP_W-1:0] imap_sec, smap_sec;
   logic [CNT_W-1:0]       imap_limit, smap_limit;

   assign imap_sec = (SEC_CLAMP_W'(inode_map_sectors) > SEC_CLAMP_W'(IMAP_MAX_SECTORS)) ?
                     SEC_CLAMP_W'(IMAP_MAX_SECTORS) : SEC_CLAMP_W'(inode_map_sectors);
   assign smap_sec = (SEC_CLAMP_W'(sector_map_sectors) > SEC_CLAMP_W'(SMAP_MAX_SECTORS)) ?
                     SEC_CLAMP_W'(SMAP_MAX_SECTORS) : SEC_CLAMP_W'(sector_map_sectors);
   assign imap_limit = CNT_W'(imap_sec) * CNT_W'(SECTOR_BYTES);
   assign smap_limit = CNT_W'(smap_sec) * CNT_W'(SECTOR_BYTES);

   // request state
   bisa_pkg::op_type             op_ff;
   logic [bisa_pkg::COUNT_W-1:0] count_ff;
   logic [CNT_W-1:0]             limit_ff;
   logic [CNT_W-1:0]             scan_addr_ff;
   logic [ADDR_W-1:0]            data_addr_ff;
   logic                         data_vld_ff;
   logic [ADDR_W-1:0]            clear_addr_ff;
   logic [ADDR_W-1:0]            run_addr_ff;
   logic [2:0]                   run_off_ff;
   logic [bisa_pkg::COUNT_W-1:0] rem_ff;
   logic [7:0]                   hit_byte_ff;
   logic [BIT_W-1:0]             bit_ff;
   logic [NW-1:0]                res_number_ff;
   bisa_pkg::status_type         res_status_ff;
   logic                         rsp_tvalid_ff;
   logic [bisa_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;

   // memories
   logic [7:0] imap_mem_ff [IMAP_BYTES];
   logic [7:0] smap_mem_ff [SMAP_BYTES];
   logic [7:0] imap_q_ff, smap_q_ff;
   logic [7:0] rdata;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [7:0]        wr_data;
   logic              imap_we, smap_we;

   assign rdata   = (op_ff == bisa_pkg::OP_ALLOC_INODE) ? imap_q_ff : smap_q_ff;
   assign rd_addr = cmd.run_read ? run_addr_ff : scan_addr_ff[ADDR_W-1:0];

   // scan
   logic [2:0]       fz;
   logic [BIT_W-1:0] bit_now;
   logic             scan_hit;

   assign fz       = first_zero(rdata);
   assign bit_now  = BIT_W'({data_addr_ff, fz});
   assign scan_hit = data_vld_ff && (rdata != bisa_pkg::FULL_BYTE);

   // run
   logic [3:0]                   avail, take;
   logic [8:0]                   mask9;
   logic [7:0]                   run_mask;
   logic [bisa_pkg::COUNT_W-1:0] rem_next;

   assign avail    = 4'd8 - {1'b0, run_off_ff};
   assign take     = (rem_ff < bisa_pkg::COUNT_W'(avail)) ? rem_ff[3:0] : avail;
   assign mask9    = (9'd1 << take) - 9'd1;
   assign run_mask = mask9[7:0] << run_off_ff;
   assign rem_next = rem_ff - bisa_pkg::COUNT_W'(take);

   always_comb begin
      stat.clear_last     = (clear_addr_ff == ADDR_W'(MAP_BYTES - 1));
      stat.req_op         = req_op;
      stat.req_count_zero = (req_count == '0);
      stat.cur_op         = op_ff;
      stat.scan_hit       = scan_hit;
      stat.scan_empty     = !data_vld_ff && (scan_addr_ff == limit_ff);
      stat.run_fits       = ((BIT_W+1)'(bit_now) + (BIT_W+1)'(count_ff)) <=
                            (BIT_W+1)'({limit_ff, 3'b000});
      stat.run_last       = (rem_next == '0);
      stat.rsp_free       = !rsp_tvalid_ff || rsp_tready;
   end

   // write address and data shared by the clear pass, loads, inode mark and run marking
   always_comb begin
      wr_addr = '0;
      wr_data = '0;
      imap_we = 1'b0;
      smap_we = 1'b0;
      if (cmd.clear_step) begin
         wr_addr = clear_addr_ff;
         imap_we = (CNT_W'(clear_addr_ff) < CNT_W'(IMAP_BYTES));
         smap_we = 1'b1;
      end else if (cmd.start) begin
         wr_addr = idx_cmp[ADDR_W-1:0];
         wr_data = req_value;
         imap_we = (req_op == bisa_pkg::OP_LOAD_INODE_MAP) && (idx_cmp < CMP_W'(IMAP_BYTES));
         smap_we = (req_op == bisa_pkg::OP_LOAD_SECTOR_MAP) && (idx_cmp < CMP_W'(SMAP_BYTES));
      end else if (cmd.mark) begin
         wr_addr = run_addr_ff;
         wr_data = hit_byte_ff | (8'd1 << run_off_ff);
         imap_we = 1'b1;
      end else if (cmd.run_write) begin
         wr_addr = run_addr_ff;
         wr_data = rdata | run_mask;
         smap_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (imap_we) begin
         imap_mem_ff[wr_addr[IMAP_AW-1:0]] <= wr_data;
      end
      imap_q_ff <= imap_mem_ff[rd_addr[IMAP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (smap_we) begin
         smap_mem_ff[wr_addr[SMAP_AW-1:0]] <= wr_data;
      end
      smap_q_ff <= smap_mem_ff[rd_addr[SMAP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff         <= req_op;
         count_ff      <= req_count;
         limit_ff      <= (req_op == bisa_pkg::OP_ALLOC_INODE) ? imap_limit : smap_limit;
         scan_addr_ff  <= '0;
         data_vld_ff   <= 1'b0;
         res_number_ff <= '0;
         res_status_ff <= bisa_pkg::STAT_OK;
      end
      if (cmd.scan_step) begin
         if (scan_addr_ff < limit_ff) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
            data_addr_ff <= scan_addr_ff[ADDR_W-1:0];
            data_vld_ff  <= 1'b1;
         end else begin
            data_vld_ff <= 1'b0;
         end
         if (scan_hit) begin
            run_addr_ff <= data_addr_ff;
            run_off_ff  <= fz;
            hit_byte_ff <= rdata;
            bit_ff      <= bit_now;
            rem_ff      <= count_ff;
         end
      end
      if (cmd.set_full) begin
         res_status_ff <= bisa_pkg::STAT_FULL;
      end
      if (cmd.mark) begin
         res_number_ff <= NW'(bit_ff);
      end
      if (cmd.run_read) begin
         res_number_ff <= NW'(bit_ff) + NW'(first_data_sector) - NW'(1);
      end
      if (cmd.run_write) begin
         if ((rdata & run_mask) != 8'd0) begin
            res_status_ff <= bisa_pkg::STAT_OVERLAP;
         end
         rem_ff      <= rem_next;
         run_off_ff  <= 3'd0;
         run_addr_ff <= run_addr_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_tdata_ff <= {5'd0, res_status_ff, res_number_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

FILE: rtl/bitmap_inode_sector_allocator_core.sv
// Top level of the bitmap inode and sector allocator: ports, config registers, checks.
//
// First-fit allocator over two byte-wide bitmaps held in on-chip memories. After reset
// the block runs a clearing pass that zeroes both maps, one byte a cycle, over
// SECTOR_BYTES * max(INODE_MAP_MAX_SECTORS, SECTOR_MAP_MAX_SECTORS) bytes (4096 with
// the defaults); no request is taken meanwhile, though configuration writes are. One
// request is worked on at a time. Loads and zero-length sector requests skip the scan
// and go straight to the result. An allocation scans the map at one byte per cycle
// through the single read port of that map's memory, up to the first byte with a clear
// bit within the in-use map size, or over all bytes in use when the map is full.
// A sector request whose run fits then reads, then writes back each map byte its run
// touches, at most 33 bytes for a 255-sector run. A finished result waits in an output
// register, and the next request is accepted while it does.
`include "bitmap_inode_sector_allocator_core_defines.svh"

module bitmap_inode_sector_allocator_core #(
   parameter int SECTOR_BYTES           = bisa_pkg::SECTOR_BYTES_DEF,
   parameter int INODE_MAP_MAX_SECTORS  = bisa_pkg::IMAP_MAX_SECTORS_DEF,
   parameter int SECTOR_MAP_MAX_SECTORS = bisa_pkg::SMAP_MAX_SECTORS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // operation[1:0], sector_count[9:2], byte_index[21:10], byte_value[29:22], zero fill
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bisa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // allocated_number[16:0], status[18:17], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bisa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bisa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bisa_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [bisa_pkg::IMAP_REG_W-1:0] inode_sectors_ff;
   logic [bisa_pkg::SMAP_REG_W-1:0] sector_sectors_ff;
   logic [bisa_pkg::FDS_W-1:0]      first_data_sector_ff;

   bisa_pkg::cmd_type       cmd;
   bisa_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_sectors_ff     <= bisa_pkg::IMAP_REG_W'(1);
         sector_sectors_ff    <= bisa_pkg::SMAP_REG_W'(8);
         first_data_sector_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bisa_pkg::CSR_INODE_MAP_SECTORS:
               inode_sectors_ff <= csr_data[bisa_pkg::IMAP_REG_W-1:0];
            bisa_pkg::CSR_SECTOR_MAP_SECTORS:
               sector_sectors_ff <= csr_data[bisa_pkg::SMAP_REG_W-1:0];
            bisa_pkg::CSR_FIRST_DATA_SECTOR:
               first_data_sector_ff <= csr_data[bisa_pkg::FDS_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   bisa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bisa_dp #(
      .SECTOR_BYTES     (SECTOR_BYTES),
      .IMAP_MAX_SECTORS (INODE_MAP_MAX_SECTORS),
      .SMAP_MAX_SECTORS (SECTOR_MAP_MAX_SECTORS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_tdata          (req_tdata),
      .inode_map_sectors  (inode_sectors_ff),
      .sector_map_sectors (sector_sectors_ff),
      .first_data_sector  (first_data_sector_ff),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata)
   );

   // set_full only ever comes with a scan step, so it stays out of this check
   `BISA_ASSERT(a_cmd_onehot, clock, reset, $onehot0({cmd.clear_step, cmd.start, cmd.scan_step, cmd.mark, cmd.run_read, cmd.run_write, cmd.publish}), "more than one datapath command")
   `BISA_ASSERT_NEVER(a_no_req_in_clear, clock, reset, cmd.clear_step && req_tready, "request accepted during clear pass")
   `BISA_ASSERT(a_publish_free, clock, reset, cmd.publish |-> (!rsp_tvalid || rsp_tready), "result overwritten before taken")
   `BISA_ASSERT(a_publish_shows, clock, reset, cmd.publish |=> rsp_tvalid, "published result not shown")

endmodule

FILE: test/bitmap_inode_sector_allocator_core_tb.sv
// Self-checking testbench for the bitmap inode and sector allocator core.
module bitmap_inode_sector_allocator_core_tb;
   import bisa_pkg::*;

   localparam int INODE_MAP_BYTES  = SECTOR_BYTES_DEF * IMAP_MAX_SECTORS_DEF;
   localparam int SECTOR_MAP_BYTES = SECTOR_BYTES_DEF * SMAP_MAX_SECTORS_DEF;
   localparam int CYCLE_LIMIT      = 20000000;
   localparam int TAIL_CYCLES      = 200;

   typedef struct {
      op_type      op;
      logic [7:0]  count;
      logic [11:0] index;
      logic [7:0]  value;
   } alloc_request_type;

   typedef struct {
      logic [16:0] number;
      status_type  status;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow copy of the block's maps and registers
   logic [7:0]  inode_bytes [INODE_MAP_BYTES];
   logic [7:0]  sector_bytes [SECTOR_MAP_BYTES];
   logic        inode_sectors_reg;
   logic [3:0]  sector_sectors_reg;
   logic [15:0] first_sector_reg;

   alloc_request_type pending_requests [$];
   alloc_result_type  expected_allocations [$];
   alloc_request_type offered_request;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int error_count = 0;
   int accepted_count = 0;
   int csr_writes = 0;
   int ok_count = 0;
   int full_count = 0;
   int overlap_count = 0;

   bitmap_inode_sector_allocator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_allocations.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // First clear bit within the first nbytes of a map, -1 when there is none.
   function automatic int first_clear_bit(input bit sector_side, input int nbytes);
      logic [7:0] cur;
      for (int j = 0; j < nbytes; j++) begin
         cur = sector_side ? sector_bytes[j] : inode_bytes[j];
         if (cur != FULL_BYTE) begin
            for (int k = 0; k < 8; k++) begin
               if (!cur[k]) return j * 8 + k;
            end
         end
      end
      return -1;
   endfunction

   function automatic alloc_result_type predict_allocation(input alloc_request_type rq);
      alloc_result_type res;
      int nsec;
      int nbytes;
      int pos;
      int b;
      res.number = '0;
      res.status = STAT_OK;
      case (rq.op)
         OP_ALLOC_INODE: begin
            nsec = (int'(inode_sectors_reg) > IMAP_MAX_SECTORS_DEF) ?
                   IMAP_MAX_SECTORS_DEF : int'(inode_sectors_reg);
            pos = first_clear_bit(1'b0, nsec * SECTOR_BYTES_DEF);
            if (pos < 0) begin
               res.status = STAT_FULL;
            end else begin
               inode_bytes[pos / 8][pos % 8] = 1'b1;
               res.number = 17'(pos);
            end
         end
         OP_ALLOC_SECTORS: begin
            nsec = (int'(sector_sectors_reg) > SMAP_MAX_SECTORS_DEF) ?
                   SMAP_MAX_SECTORS_DEF : int'(sector_sectors_reg);
            nbytes = nsec * SECTOR_BYTES_DEF;
            if (rq.count != 0) begin
               pos = first_clear_bit(1'b1, nbytes);
               if (pos < 0 || pos + int'(rq.count) > nbytes * 8) begin
                  res.status = STAT_FULL;
               end else begin
                  for (b = pos; b < pos + int'(rq.count); b++) begin
                     if (sector_bytes[b / 8][b % 8]) res.status = STAT_OVERLAP;
                     sector_bytes[b / 8][b % 8] = 1'b1;
                  end
                  // bit zero with sector base zero wraps to all ones
                  res.number = 17'(pos + int'(first_sector_reg) - 1);
               end
            end
         end
         OP_LOAD_INODE_MAP: begin
            if (rq.index < INODE_MAP_BYTES) inode_bytes[rq.index] = rq.value;
         end
         default: begin
            if (rq.index < SECTOR_MAP_BYTES) sector_bytes[rq.index] = rq.value;
         end
      endcase
      return res;
   endfunction

   // request driver: predict on acceptance, then offer the next pending request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_allocations.push_back(predict_allocation(offered_request));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_request = pending_requests.pop_front();
               req_tdata <= {2'b00, offered_request.value, offered_request.index,
                             offered_request.count, offered_request.op};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      alloc_result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_allocations.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               exp = expected_allocations.pop_front();
               case (exp.status)
                  STAT_OK:      ok_count++;
                  STAT_FULL:    full_count++;
                  default:      overlap_count++;
               endcase
               if (rsp_tdata[16:0] !== exp.number)
                  report_mismatch($sformatf("allocated_number %h, expected %h",
                                            rsp_tdata[16:0], exp.number));
               if (rsp_tdata[18:17] !== exp.status)
                  report_mismatch($sformatf("status %h, expected %s",
                                            rsp_tdata[18:17], exp.status.name()));
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // settle at a falling edge so that every update of the rising edge is visible
   task automatic wait_for_quiet();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_allocations.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_put(input csr_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_INODE_MAP_SECTORS:  inode_sectors_reg = val[0];
         CSR_SECTOR_MAP_SECTORS: sector_sectors_reg = val[3:0];
         default:                first_sector_reg = val;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(input logic imap, input logic [3:0] smap,
                                 input logic [15:0] base);
      wait_for_quiet();
      csr_put(CSR_INODE_MAP_SECTORS, {15'd0, imap});
      csr_put(CSR_SECTOR_MAP_SECTORS, {12'd0, smap});
      csr_put(CSR_FIRST_DATA_SECTOR, base);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_request(input op_type op, input logic [7:0] count,
                                input logic [11:0] index, input logic [7:0] value);
      alloc_request_type rq;
      rq.op = op;
      rq.count = count;
      rq.index = index;
      rq.value = value;
      pending_requests.push_back(rq);
   endtask

   // Loads mostly hit the low bytes so that first-fit scans stay short.
   task automatic queue_random(input int n);
      alloc_request_type rq;
      int pick;
      for (int i = 0; i < n; i++) begin
         rq.count = 8'($urandom_range(255));
         rq.index = 12'($urandom_range(4095));
         rq.value = 8'($urandom_range(255));
         pick = $urandom_range(99);
         if (pick < 30) begin
            rq.op = OP_ALLOC_INODE;
         end else if (pick < 60) begin
            rq.op = OP_ALLOC_SECTORS;
            pick = $urandom_range(99);
            if (pick < 3)       rq.count = 8'd0;
            else if (pick < 70) rq.count = 8'($urandom_range(8, 1));
            else if (pick < 90) rq.count = 8'($urandom_range(64, 9));
            else                rq.count = 8'($urandom_range(255, 65));
         end else begin
            rq.op = (pick < 75) ? OP_LOAD_INODE_MAP : OP_LOAD_SECTOR_MAP;
            if ($urandom_range(99) < 70) rq.index = 12'($urandom_range(63));
            if ($urandom_range(1) == 0) rq.value = 8'd0;
         end
         pending_requests.push_back(rq);
      end
   endtask

   task automatic run_phase(input logic imap, input logic [3:0] smap, input logic [15:0] base,
                            input int idle_pct, input int hold_pct, input int n);
      apply_settings(imap, smap, base);
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      queue_random(n);
   endtask

   initial begin
      foreach (inode_bytes[j]) inode_bytes[j] = 8'd0;
      foreach (sector_bytes[j]) sector_bytes[j] = 8'd0;
      inode_sectors_reg = 1'b1;
      sector_sectors_reg = 4'd8;
      first_sector_reg = 16'd0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: one sector map sector so that the map fills quickly
      apply_settings(1'b1, 4'd1, 16'd0);
      queue_request(OP_ALLOC_SECTORS, 8'd1, 12'd0, 8'd0);      // wraps below zero
      queue_request(OP_ALLOC_SECTORS, 8'd0, 12'd0, 8'd0);      // empty run
      queue_request(OP_ALLOC_INODE, 8'd0, 12'd0, 8'd0);
      queue_request(OP_LOAD_INODE_MAP, 8'd0, 12'd0, 8'hFF);
      queue_request(OP_ALLOC_INODE, 8'hFF, 12'hFFF, 8'hFF);
      queue_request(OP_LOAD_INODE_MAP, 8'd0, 12'hFFF, 8'd0);   // beyond the map, dropped
      queue_request(OP_LOAD_SECTOR_MAP, 8'd0, 12'd0, 8'hF0);
      queue_request(OP_ALLOC_SECTORS, 8'd8, 12'd0, 8'd0);      // runs over set bits
      queue_request(OP_LOAD_SECTOR_MAP, 8'd0, 12'hFFF, 8'hFF);
      for (int i = 0; i < 16; i++)
         queue_request(OP_ALLOC_SECTORS, 8'hFF, 12'd0, 8'd0);
      queue_request(OP_ALLOC_SECTORS, 8'hFF, 12'd0, 8'd0);     // run does not fit
      queue_request(OP_ALLOC_SECTORS, 8'd8, 12'd0, 8'd0);      // takes the last bits
      queue_request(OP_ALLOC_SECTORS, 8'd1, 12'd0, 8'd0);      // map completely full

      run_phase(1'b1, 4'd8, 16'($urandom_range(65535)), 0, 0, 300);
      run_phase(1'b1, 4'd2, 16'hFFFF, 54, 0, 250);
      run_phase(1'b0, 4'd1, 16'd0, 0, 54, 250);
      run_phase(1'b1, 4'd15, 16'($urandom_range(65535)), 29, 29, 250);
      run_phase(1'b1, 4'd0, 16'($urandom_range(65535)), 0, 0, 60);
      run_phase(1'b1, 4'd8, 16'hFFFF, 54, 54, 190);

      wait_for_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d requests over %0d register writes in %0d cycles",
               accepted_count, csr_writes, cycle_count);
      $display("results: %0d ok, %0d full, %0d overlap, %0d mismatches",
               ok_count, full_count, overlap_count, error_count);
      if (error_count == 0 && expected_allocations.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
